// ----- src/sound_container_header_parser_defines.svh -----
// Assertion macros for the checker file of the header parser.
// No dependencies; include by bare file name.
`ifndef SOUND_CONTAINER_HEADER_PARSER_DEFINES_SVH
`define SOUND_CONTAINER_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scp assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scp assertion failed: next-cycle implication");

`endif

// ----- src/scp_pkg.sv -----
// Types and constants of the sound container header parser.
// No dependencies; used by the top level, the checker and the testbench.
package scp_pkg;

  localparam int PositionBitsDefault = 32;

  localparam logic [31:0] TagGsnd = 32'h444E_5347;
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam int GsndHead = 24;
  localparam int WavMin   = 44;
  localparam int FmtMin   = 16;
  localparam int ChunkHeaderBytes = 8;

  typedef enum logic [1:0] {
    CONT_NONE = 2'd0,
    CONT_GSND = 2'd1,
    CONT_RIFF = 2'd2
  } container_t;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_BODY     = 2'd1,
    PH_BODY_ODD = 2'd2,
    PH_PAD      = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    CK_OTHER = 2'd0,
    CK_FMT   = 2'd1,
    CK_DATA  = 2'd2
  } chunk_t;

endpackage

// ----- src/scp_stream_if.sv -----
// Valid/ready channels of the header parser: file bytes in, verdicts out.
// No dependencies.
interface scp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source(output valid, output data_byte, output final_byte, input ready);
  modport sink(input valid, input data_byte, input final_byte, output ready);
endinterface

interface scp_verdict_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  container;
  logic [1:0]  channel_count;
  logic [4:0]  sample_bits;
  logic [31:0] sample_rate;
  logic [31:0] data_offset;
  logic [31:0] data_size;

  modport source(output valid, output accepted, output container, output channel_count,
                 output sample_bits, output sample_rate, output data_offset,
                 output data_size, input ready);
  modport sink(input valid, input accepted, input container, input channel_count,
               input sample_bits, input sample_rate, input data_offset,
               input data_size, output ready);
endinterface

// ----- src/sound_container_header_parser.sv -----
// Streaming RIFF/WAVE and GSND sound header checker, top level.
// Depends on scp_pkg and the channels in scp_stream_if.sv.
//
// The parser takes one file byte per clock cycle and returns one verdict for
// each byte marked final, through the input register and the verdict register.
// Each request goes into an input register and is parsed by one pass of
// counter and compare logic into the header state; a final byte also loads the
// verdict register and returns the parser to its reset state for the next file.
// Non-final bytes never stall; a final byte waits in the input register only
// while the previous verdict is still untaken at the output.
module sound_container_header_parser #(
  parameter int POSITION_BITS = scp_pkg::PositionBitsDefault
) (
  input logic           clk,
  input logic           rst_n,
  scp_byte_if.sink      in_ch,
  scp_verdict_if.source out_ch
);

  localparam logic [POSITION_BITS-1:0] PosLimit = {POSITION_BITS{1'b1}};

  logic                     in_vld_r;
  logic [7:0]               in_byte_r;
  logic                     in_fin_r;
  logic                     advance;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  scp_pkg::container_t      kind_r, kind_nxt;
  logic [63:0]              rb_r, rb_nxt;
  logic [31:0]              left_r, left_nxt;
  scp_pkg::phase_t          phase_r, phase_nxt;
  scp_pkg::chunk_t          chunk_r, chunk_nxt;
  logic [4:0]               bidx_r, bidx_nxt;
  logic [15:0]              code_r, code_nxt;
  logic [15:0]              chan_r, chan_nxt;
  logic [15:0]              bits_r, bits_nxt;
  logic [31:0]              rate_r, rate_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [63:0]              len_r, len_nxt;
  logic                     seen_r, seen_nxt;
  logic                     failed_r, failed_nxt;

  logic                     at_limit;
  logic [15:0]              top16;
  logic [31:0]              csize;
  logic [31:0]              left_dec;

  logic                     ok;
  logic [POSITION_BITS-1:0] start_sel;
  logic                     frame_ok;

  logic                     out_vld_r;
  logic                     out_acc_r;
  logic [1:0]               out_cont_r;
  logic [1:0]               out_chan_r;
  logic [4:0]               out_bits_r;
  logic [31:0]              out_rate_r;
  logic [31:0]              out_off_r;
  logic [31:0]              out_size_r;

  assign advance     = in_vld_r && !(in_fin_r && out_vld_r && !out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  assign at_limit = (pos_r == PosLimit);
  assign rb_nxt   = {in_byte_r, rb_r[63:8]};
  assign top16    = rb_nxt[63:48];
  assign csize    = rb_nxt[63:32];
  assign left_dec = left_r - 32'd1;

  always_comb begin
    kind_nxt   = kind_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    chunk_nxt  = chunk_r;
    bidx_nxt   = bidx_r;
    code_nxt   = code_r;
    chan_nxt   = chan_r;
    bits_nxt   = bits_r;
    rate_nxt   = rate_r;
    start_nxt  = start_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    failed_nxt = failed_r | at_limit;
    pos_nxt    = at_limit ? pos_r : pos_r + POSITION_BITS'(1);

    if (pos_r == POSITION_BITS'(3)) begin
      priority if (rb_nxt[63:32] == scp_pkg::TagGsnd) begin
        kind_nxt = scp_pkg::CONT_GSND;
      end else if (rb_nxt[63:32] == scp_pkg::TagRiff) begin
        kind_nxt = scp_pkg::CONT_RIFF;
      end else begin
        kind_nxt = scp_pkg::CONT_NONE;
      end
    end else if (kind_r == scp_pkg::CONT_GSND) begin
      if (pos_r == POSITION_BITS'(5) && top16 != 16'd1) failed_nxt = 1'b1;
      if (pos_r == POSITION_BITS'(7) && !top16[0]) failed_nxt = 1'b1;
      if (pos_r == POSITION_BITS'(9)) chan_nxt = top16;
      if (pos_r == POSITION_BITS'(11)) bits_nxt = top16;
      if (pos_r == POSITION_BITS'(15)) rate_nxt = rb_nxt[63:32];
      if (pos_r == POSITION_BITS'(23)) len_nxt = rb_nxt;
    end else if (kind_r == scp_pkg::CONT_RIFF) begin
      if (pos_r == POSITION_BITS'(11)) begin
        if (rb_nxt[63:32] != scp_pkg::TagWave) begin
          kind_nxt = scp_pkg::CONT_NONE;
        end else begin
          phase_nxt = scp_pkg::PH_HEADER;
          left_nxt  = 32'(scp_pkg::ChunkHeaderBytes);
        end
      end else if (pos_r > POSITION_BITS'(11) && !failed_nxt) begin
        unique case (phase_r)
          scp_pkg::PH_HEADER: begin
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              priority if (rb_nxt[31:0] == scp_pkg::TagFmt) begin
                chunk_nxt = scp_pkg::CK_FMT;
              end else if (rb_nxt[31:0] == scp_pkg::TagData) begin
                chunk_nxt = scp_pkg::CK_DATA;
              end else begin
                chunk_nxt = scp_pkg::CK_OTHER;
              end
              bidx_nxt = 5'd0;
              if (rb_nxt[31:0] == scp_pkg::TagFmt && csize < 32'(scp_pkg::FmtMin)) begin
                failed_nxt = 1'b1;
              end
              if (rb_nxt[31:0] != scp_pkg::TagFmt && rb_nxt[31:0] == scp_pkg::TagData) begin
                start_nxt = pos_r + POSITION_BITS'(1);
                len_nxt   = 64'(csize);
                seen_nxt  = 1'b1;
              end
              if (csize == 32'd0) begin
                left_nxt = 32'(scp_pkg::ChunkHeaderBytes);
              end else begin
                left_nxt  = csize;
                phase_nxt = csize[0] ? scp_pkg::PH_BODY_ODD : scp_pkg::PH_BODY;
              end
            end
          end
          scp_pkg::PH_BODY, scp_pkg::PH_BODY_ODD: begin
            if (chunk_r == scp_pkg::CK_FMT) begin
              if (bidx_r == 5'd1) code_nxt = top16;
              if (bidx_r == 5'd3) chan_nxt = top16;
              if (bidx_r == 5'd7) rate_nxt = rb_nxt[63:32];
              if (bidx_r == 5'd15) bits_nxt = top16;
            end
            if (bidx_r < 5'd16) bidx_nxt = bidx_r + 5'd1;
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              if (phase_r == scp_pkg::PH_BODY_ODD) begin
                phase_nxt = scp_pkg::PH_PAD;
              end else begin
                phase_nxt = scp_pkg::PH_HEADER;
                left_nxt  = 32'(scp_pkg::ChunkHeaderBytes);
              end
            end
          end
          scp_pkg::PH_PAD: begin
            phase_nxt = scp_pkg::PH_HEADER;
            left_nxt  = 32'(scp_pkg::ChunkHeaderBytes);
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case ({bits_nxt == 16'd16, chan_nxt == 16'd2})
      2'b00:   frame_ok = 1'b1;
      2'b11:   frame_ok = (len_nxt[1:0] == 2'b00);
      default: frame_ok = !len_nxt[0];
    endcase
  end

  always_comb begin
    ok        = !failed_nxt;
    start_sel = start_nxt;
    unique case (kind_nxt)
      scp_pkg::CONT_GSND: begin
        start_sel = POSITION_BITS'(scp_pkg::GsndHead);
        ok = ok && pos_nxt >= POSITION_BITS'(scp_pkg::GsndHead)
                && len_nxt <= 64'(pos_nxt - POSITION_BITS'(scp_pkg::GsndHead));
      end
      scp_pkg::CONT_RIFF: begin
        ok = ok && pos_nxt >= POSITION_BITS'(scp_pkg::WavMin)
                && phase_nxt != scp_pkg::PH_BODY && phase_nxt != scp_pkg::PH_BODY_ODD
                && code_nxt == 16'd1 && seen_nxt;
      end
      default: ok = 1'b0;
    endcase
    ok = ok && len_nxt != 64'd0 && rate_nxt != 32'd0
            && (chan_nxt == 16'd1 || chan_nxt == 16'd2)
            && (bits_nxt == 16'd8 || bits_nxt == 16'd16)
            && 64'(start_sel) <= 64'hFFFF_FFFF && len_nxt[63:32] == 32'd0
            && frame_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= '0;
      kind_r    <= scp_pkg::CONT_NONE;
      rb_r      <= '0;
      left_r    <= '0;
      phase_r   <= scp_pkg::PH_HEADER;
      chunk_r   <= scp_pkg::CK_OTHER;
      bidx_r    <= '0;
      code_r    <= '0;
      chan_r    <= '0;
      bits_r    <= '0;
      rate_r    <= '0;
      start_r   <= '0;
      len_r     <= '0;
      seen_r    <= 1'b0;
      failed_r  <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        if (in_fin_r) begin
          pos_r    <= '0;
          kind_r   <= scp_pkg::CONT_NONE;
          rb_r     <= '0;
          left_r   <= '0;
          phase_r  <= scp_pkg::PH_HEADER;
          chunk_r  <= scp_pkg::CK_OTHER;
          bidx_r   <= '0;
          code_r   <= '0;
          chan_r   <= '0;
          bits_r   <= '0;
          rate_r   <= '0;
          start_r  <= '0;
          len_r    <= '0;
          seen_r   <= 1'b0;
          failed_r <= 1'b0;
        end else begin
          pos_r    <= pos_nxt;
          kind_r   <= kind_nxt;
          rb_r     <= rb_nxt;
          left_r   <= left_nxt;
          phase_r  <= phase_nxt;
          chunk_r  <= chunk_nxt;
          bidx_r   <= bidx_nxt;
          code_r   <= code_nxt;
          chan_r   <= chan_nxt;
          bits_r   <= bits_nxt;
          rate_r   <= rate_nxt;
          start_r  <= start_nxt;
          len_r    <= len_nxt;
          seen_r   <= seen_nxt;
          failed_r <= failed_nxt;
        end
      end
      if (advance && in_fin_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_fin_r  <= in_ch.final_byte;
    end
    if (advance && in_fin_r) begin
      out_acc_r  <= ok;
      out_cont_r <= kind_nxt;
      out_chan_r <= ok ? chan_nxt[1:0] : 2'd0;
      out_bits_r <= ok ? bits_nxt[4:0] : 5'd0;
      out_rate_r <= ok ? rate_nxt : 32'd0;
      out_off_r  <= ok ? 32'(start_sel) : 32'd0;
      out_size_r <= ok ? len_nxt[31:0] : 32'd0;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.accepted      = out_acc_r;
  assign out_ch.container     = out_cont_r;
  assign out_ch.channel_count = out_chan_r;
  assign out_ch.sample_bits   = out_bits_r;
  assign out_ch.sample_rate   = out_rate_r;
  assign out_ch.data_offset   = out_off_r;
  assign out_ch.data_size     = out_size_r;

endmodule

// ----- src/scp_checker.sv -----
// Port-level checks of the sound container header parser, bound to its top.
// Depends on scp_pkg and sound_container_header_parser_defines.svh.
`include "sound_container_header_parser_defines.svh"

module scp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_final_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [1:0]  out_container,
  input logic [1:0]  out_channel_count,
  input logic [4:0]  out_sample_bits,
  input logic [31:0] out_data_size
);

  `SCP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_accepted) && $stable(out_data_size) && $stable(out_container))

  `SCP_ASSERT_IMPLY(a_verdict_follows_final, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready && in_final_byte, 2))

  `SCP_ASSERT_IMPLY(a_accept_format, clk, rst_n, out_valid && out_accepted, out_container != scp_pkg::CONT_NONE && (out_channel_count == 2'd1 || out_channel_count == 2'd2) && (out_sample_bits == 5'd8 || out_sample_bits == 5'd16))

  `SCP_ASSERT_NEXT(a_body_no_stall, clk, rst_n, in_valid && in_ready && !in_final_byte, in_ready)

endmodule

bind sound_container_header_parser scp_checker u_scp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_final_byte    (in_ch.final_byte),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_container    (out_ch.container),
  .out_channel_count(out_ch.channel_count),
  .out_sample_bits  (out_ch.sample_bits),
  .out_data_size    (out_ch.data_size)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for sound_container_header_parser: streams GSND, RIFF/WAVE and
// malformed files through the byte channel and checks each verdict against a local predictor.
// Depends on scp_pkg, scp_stream_if.sv and the parser RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } file_byte_t;

  typedef struct packed {
    logic                accepted;
    scp_pkg::container_t container;
    logic [1:0]          channels;
    logic [4:0]          bits;
    logic [31:0]         rate;
    logic [31:0]         offset;
    logic [31:0]         size;
  } verdict_t;

  localparam logic [63:0] PosLimit = (64'd1 << scp_pkg::PositionBitsDefault) - 64'd1;
  localparam logic [31:0] TagAvi  = 32'h2049_5641;
  localparam logic [31:0] TagList = 32'h5453_494C;
  localparam logic [31:0] TagJunk = 32'h6B6E_756A;

  logic clk = 1'b0;
  logic rst_n;

  scp_byte_if    in_ch();
  scp_verdict_if out_ch();

  sound_container_header_parser u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  file_byte_t pending_bytes[$];
  verdict_t   verdicts_due[$];
  logic [7:0] file_bytes[$];
  logic       byte_taken = 1'b0;
  int         mismatches = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         hold_len = 0;
  int         held = 0;

  // Parser state mirror
  logic [63:0]         pos_cnt;
  scp_pkg::container_t kind;
  logic [63:0]         window;
  logic [63:0]         chunk_left;
  scp_pkg::phase_t     phase;
  scp_pkg::chunk_t     chunk;
  int unsigned         body_idx;
  logic [15:0]         f_code, f_chans, f_bits;
  logic [31:0]         f_rate;
  logic [63:0]         pcm_off, pcm_len;
  logic                pcm_found, broken;

  initial begin
    forever #5 clk = ~clk;
  end

  function void clear_parser();
    pos_cnt = '0;
    kind = scp_pkg::CONT_NONE;
    window = '0;
    chunk_left = '0;
    phase = scp_pkg::PH_HEADER;
    chunk = scp_pkg::CK_OTHER;
    body_idx = 0;
    f_code = '0;
    f_chans = '0;
    f_bits = '0;
    f_rate = '0;
    pcm_off = '0;
    pcm_len = '0;
    pcm_found = 1'b0;
    broken = 1'b0;
  endfunction

  function void walk_chunk(input logic [63:0] pos);
    logic [31:0] tag;
    logic [63:0] csize;
    tag = window[31:0];
    csize = {32'd0, window[63:32]};
    if (phase == scp_pkg::PH_HEADER) begin
      chunk_left = chunk_left - 64'd1;
      if (chunk_left == 0) begin
        chunk = (tag == scp_pkg::TagFmt) ? scp_pkg::CK_FMT :
                (tag == scp_pkg::TagData) ? scp_pkg::CK_DATA : scp_pkg::CK_OTHER;
        body_idx = 0;
        if (chunk == scp_pkg::CK_FMT && csize < scp_pkg::FmtMin) broken = 1'b1;
        if (chunk == scp_pkg::CK_DATA) begin
          pcm_off = pos + 64'd1;
          pcm_len = csize;
          pcm_found = 1'b1;
        end
        if (csize == 0) begin
          chunk_left = scp_pkg::ChunkHeaderBytes;
        end else begin
          chunk_left = csize;
          phase = csize[0] ? scp_pkg::PH_BODY_ODD : scp_pkg::PH_BODY;
        end
      end
    end else if (phase == scp_pkg::PH_BODY || phase == scp_pkg::PH_BODY_ODD) begin
      if (chunk == scp_pkg::CK_FMT) begin
        case (body_idx)
          1: f_code = window[63:48];
          3: f_chans = window[63:48];
          7: f_rate = window[63:32];
          15: f_bits = window[63:48];
          default: ;
        endcase
      end
      if (body_idx < 16) body_idx++;
      chunk_left = chunk_left - 64'd1;
      if (chunk_left == 0) begin
        if (phase == scp_pkg::PH_BODY_ODD) begin
          phase = scp_pkg::PH_PAD;
        end else begin
          phase = scp_pkg::PH_HEADER;
          chunk_left = scp_pkg::ChunkHeaderBytes;
        end
      end
    end else begin
      phase = scp_pkg::PH_HEADER;
      chunk_left = scp_pkg::ChunkHeaderBytes;
    end
  endfunction

  function automatic logic parse_byte(input logic [7:0] b, input logic fin,
                                      output verdict_t v);
    logic [63:0] pos, start, len, frame;
    logic [31:0] magic;
    logic [15:0] top16;
    logic        ok;
    pos = pos_cnt;
    start = '0;
    len = '0;
    v = '0;
    if (pos >= PosLimit) broken = 1'b1;
    window = {b, window[63:8]};
    top16 = window[63:48];
    magic = window[63:32];
    if (pos == 3) begin
      kind = (magic == scp_pkg::TagGsnd) ? scp_pkg::CONT_GSND :
             (magic == scp_pkg::TagRiff) ? scp_pkg::CONT_RIFF : scp_pkg::CONT_NONE;
    end else if (kind == scp_pkg::CONT_GSND) begin
      if (pos == 5 && top16 != 16'd1) broken = 1'b1;
      else if (pos == 7 && !top16[0]) broken = 1'b1;
      else if (pos == 9) f_chans = top16;
      else if (pos == 11) f_bits = top16;
      else if (pos == 15) f_rate = magic;
      else if (pos == 23) pcm_len = window;
    end else if (kind == scp_pkg::CONT_RIFF) begin
      if (pos == 11) begin
        if (magic != scp_pkg::TagWave) begin
          kind = scp_pkg::CONT_NONE;
        end else begin
          phase = scp_pkg::PH_HEADER;
          chunk_left = scp_pkg::ChunkHeaderBytes;
        end
      end else if (pos > 11 && !broken) begin
        walk_chunk(pos);
      end
    end
    if (pos < PosLimit) pos = pos + 64'd1;
    pos_cnt = pos;
    if (!fin) return 1'b0;

    ok = !broken;
    if (kind == scp_pkg::CONT_GSND) begin
      ok = ok && pos >= scp_pkg::GsndHead && pcm_len <= pos - scp_pkg::GsndHead;
      start = scp_pkg::GsndHead;
      len = pcm_len;
    end else if (kind == scp_pkg::CONT_RIFF) begin
      ok = ok && pos >= scp_pkg::WavMin && phase != scp_pkg::PH_BODY
              && phase != scp_pkg::PH_BODY_ODD;
      ok = ok && f_code == 16'd1 && pcm_found;
      start = pcm_off;
      len = pcm_len;
    end else begin
      ok = 1'b0;
    end
    ok = ok && len != 0 && f_rate != 0;
    ok = ok && (f_chans == 16'd1 || f_chans == 16'd2);
    ok = ok && (f_bits == 16'd8 || f_bits == 16'd16);
    ok = ok && start <= 64'hFFFF_FFFF && len <= 64'hFFFF_FFFF;
    if (ok) begin
      frame = (f_bits / 16'd8) * f_chans;
      ok = (len % frame) == 0;
    end
    v.container = kind;
    if (ok) begin
      v.accepted = 1'b1;
      v.channels = f_chans[1:0];
      v.bits = f_bits[4:0];
      v.rate = f_rate;
      v.offset = start[31:0];
      v.size = len[31:0];
    end
    clear_parser();
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Request driver
  always @(negedge clk) begin
    file_byte_t next_req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pending_bytes.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= next_req.value;
        in_ch.final_byte <= next_req.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Verdict receiver, with an optional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (held < hold_len) begin
      out_ch.ready <= 1'b0;
      held <= held + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t computed, oldest;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.data_byte, in_ch.final_byte, computed))
          verdicts_due.push_back(computed);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual container %0d accepted %0b",
                   $time, out_ch.container, out_ch.accepted);
          mismatches++;
        end else begin
          oldest = verdicts_due.pop_front();
          check_field("accepted", 32'(out_ch.accepted), 32'(oldest.accepted));
          check_field("container", 32'(out_ch.container), 32'(oldest.container));
          check_field("channel_count", 32'(out_ch.channel_count), 32'(oldest.channels));
          check_field("sample_bits", 32'(out_ch.sample_bits), 32'(oldest.bits));
          check_field("sample_rate", out_ch.sample_rate, oldest.rate);
          check_field("data_offset", out_ch.data_offset, oldest.offset);
          check_field("data_size", out_ch.data_size, oldest.size);
        end
      end
    end
  end

  task add_le(input logic [63:0] val, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(val[8*i +: 8]);
  endtask

  task add_noise(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom_range(255)));
  endtask

  task add_chunk(input logic [31:0] tag, input logic [31:0] size, input int body,
                 input logic pad);
    add_le(tag, 4);
    add_le(size, 4);
    add_noise(body);
    if (pad && size[0]) add_noise(1);
  endtask

  task add_fmt(input logic [31:0] size, input logic [15:0] code, input logic [15:0] chans,
               input logic [15:0] bits, input logic [31:0] rate);
    add_le(scp_pkg::TagFmt, 4);
    add_le(size, 4);
    if (size < scp_pkg::FmtMin) begin
      add_noise(size);
    end else begin
      add_le(code, 2);
      add_le(chans, 2);
      add_le(rate, 4);
      add_noise(6);
      add_le(bits, 2);
      add_noise(size - scp_pkg::FmtMin);
    end
    if (size[0]) add_noise(1);
  endtask

  task add_riff_head(input logic [31:0] form);
    add_le(scp_pkg::TagRiff, 4);
    add_noise(4);
    add_le(form, 4);
  endtask

  task add_gsnd(input logic [15:0] version, input logic [15:0] flags,
                input logic [15:0] chans, input logic [15:0] bits,
                input logic [31:0] rate, input logic [63:0] len);
    add_le(scp_pkg::TagGsnd, 4);
    add_le(version, 2);
    add_le(flags, 2);
    add_le(chans, 2);
    add_le(bits, 2);
    add_le(rate, 4);
    add_le(len, 8);
  endtask

  task send_file();
    file_byte_t req;
    for (int i = 0; i < file_bytes.size(); i++) begin
      req.value = file_bytes[i];
      req.last = (i == file_bytes.size() - 1);
      pending_bytes.push_back(req);
    end
    file_bytes.delete();
  endtask

  function automatic logic [15:0] pick_chans();
    int r;
    r = $urandom_range(99);
    if (r < 85) return 16'($urandom_range(1, 2));
    if (r < 95) return ($urandom_range(1) != 0) ? 16'd0 : 16'd3;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_bits();
    int r;
    r = $urandom_range(99);
    if (r < 85) return ($urandom_range(1) != 0) ? 16'd8 : 16'd16;
    if (r < 95) return 16'($urandom_range(0, 24));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_rate();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 10) return 32'hFFFF_FFFF;
    return $urandom_range(1, 200000);
  endfunction

  function automatic logic [31:0] pick_len(input logic [15:0] chans, input logic [15:0] bits);
    logic [31:0] frame;
    frame = (bits / 16'd8) * chans;
    if ($urandom_range(99) < 75 && frame >= 1 && frame <= 4)
      return frame * $urandom_range(1, 4);
    return $urandom_range(0, 12);
  endfunction

  task add_random_file();
    logic [15:0] ch, bt, flags;
    logic [31:0] rt, dlen, fsize;
    int pick, tail;
    ch = pick_chans();
    bt = pick_bits();
    rt = pick_rate();
    dlen = pick_len(ch, bt);
    pick = $urandom_range(99);
    if (pick < 35) begin
      flags = 16'($urandom);
      if ($urandom_range(99) < 88) flags[0] = 1'b1;
      if ($urandom_range(99) < 5) begin
        add_gsnd(16'd1, flags, ch, bt, rt, {32'($urandom), 32'($urandom)});
        add_noise($urandom_range(0, 3));
      end else begin
        add_gsnd(($urandom_range(99) < 92) ? 16'd1 : 16'($urandom), flags, ch, bt, rt, dlen);
        add_noise(($urandom_range(99) < 85) ? dlen + $urandom_range(0, 3)
                                            : $urandom_range(0, dlen));
      end
    end else if (pick < 80) begin
      add_riff_head(($urandom_range(99) < 95) ? scp_pkg::TagWave : $urandom);
      if ($urandom_range(99) < 30) begin
        fsize = $urandom_range(0, 5);
        add_chunk($urandom, fsize, fsize, 1'b1);
      end
      if ($urandom_range(99) < 10) add_chunk(scp_pkg::TagData, dlen, dlen, 1'b1);
      tail = $urandom_range(99);
      fsize = (tail < 85) ? 32'd16 : (tail < 95) ? $urandom_range(17, 21) : $urandom_range(0, 15);
      add_fmt(fsize, ($urandom_range(99) < 93) ? 16'd1 : 16'($urandom_range(0, 3)),
              ch, bt, rt);
      tail = $urandom_range(99);
      if (tail < 70) begin
        add_chunk(scp_pkg::TagData, dlen, dlen, $urandom_range(99) < 75);
      end else if (tail < 80) begin
        add_chunk(scp_pkg::TagData, dlen, dlen, 1'b1);
        add_noise($urandom_range(1, 7));
      end else if (tail < 90) begin
        add_chunk(scp_pkg::TagData, dlen + $urandom_range(1, 9), dlen, 1'b0);
      end else begin
        add_chunk(scp_pkg::TagData, dlen, dlen, 1'b1);
        add_fmt(32'd16, 16'd1, pick_chans(), pick_bits(), pick_rate());
      end
    end else begin
      case ($urandom_range(2))
        1: add_le(scp_pkg::TagRiff, 4);
        2: add_le(scp_pkg::TagGsnd, 4);
        default: ;
      endcase
      add_noise($urandom_range(1, 14));
    end
  endtask

  task wait_for_verdicts();
    while (pending_bytes.size() != 0 || in_ch.valid || verdicts_due.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  task run_random_phase(input int idle, input int stall);
    int made_bytes, made_files;
    idle_pct = idle;
    stall_pct = stall;
    made_bytes = 0;
    made_files = 0;
    while (made_bytes < 24 || made_files < 1) begin
      add_random_file();
      made_bytes += file_bytes.size();
      made_files++;
      send_file();
    end
    wait_for_verdicts();
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.final_byte = 1'b0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    clear_parser();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // Short and unrecognized files
    add_noise(1);
    send_file();
    add_le(32'h0046_4952, 3);
    send_file();
    add_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_file();
    add_le(32'd0, 4);
    send_file();
    add_le(scp_pkg::TagRiff, 4);
    add_le(32'd0, 4);
    send_file();
    add_riff_head(TagAvi);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd4, 4, 1'b1);
    send_file();

    // GSND header cases
    add_gsnd(16'd1, 16'd1, 16'd2, 16'd16, 32'd44100, 64'd8);
    add_noise(8);
    send_file();
    add_gsnd(16'd2, 16'd1, 16'd1, 16'd8, 32'd8000, 64'd4);
    add_noise(4);
    send_file();
    add_gsnd(16'd1, 16'hFFFE, 16'd1, 16'd8, 32'd8000, 64'd4);
    add_noise(4);
    send_file();
    add_gsnd(16'd1, 16'd1, 16'd1, 16'd8, 32'd8000, 64'd12);
    add_noise(4);
    send_file();
    add_gsnd(16'd1, 16'd1, 16'd1, 16'd8, 32'd8000, 64'd0);
    void'(file_bytes.pop_back());
    send_file();
    add_gsnd(16'd1, 16'd1, 16'd1, 16'd8, 32'd8000, 64'h1_0000_0000);
    send_file();
    add_gsnd(16'd1, 16'd1, 16'd1, 16'd8, 32'd0, 64'd2);
    add_noise(2);
    send_file();
    add_gsnd(16'd1, 16'd1, 16'd3, 16'd24, 32'd8000, 64'd9);
    add_noise(9);
    send_file();
    add_gsnd(16'd1, 16'd1, 16'd2, 16'd16, 32'hFFFF_FFFF, 64'd6);
    add_noise(6);
    send_file();
    add_gsnd(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_file();

    // RIFF/WAVE chunk walk cases
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd5, 5, 1'b1);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd5, 5, 1'b0);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd8, 3, 1'b0);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd2, 16'd8, 32'd22050);
    add_chunk(scp_pkg::TagData, 32'd4, 4, 1'b1);
    add_noise(3);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd14, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd4, 4, 1'b1);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd3, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd4, 4, 1'b1);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_chunk(TagList, 32'd3, 3, 1'b1);
    add_chunk(TagJunk, 32'd0, 0, 1'b1);
    add_fmt(32'd17, 16'd1, 16'd1, 16'd8, 32'd11025);
    add_chunk(scp_pkg::TagData, 32'd3, 3, 1'b1);
    add_fmt(32'd16, 16'd1, 16'd2, 16'd16, 32'd48000);
    add_chunk(scp_pkg::TagData, 32'd8, 8, 1'b1);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd16, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'd0, 0, 1'b1);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(TagList, 32'd6, 6, 1'b1);
    send_file();
    add_riff_head(scp_pkg::TagWave);
    add_fmt(32'd16, 16'd1, 16'd1, 16'd8, 32'd8000);
    add_chunk(scp_pkg::TagData, 32'hFFFF_FFFF, 2, 1'b0);
    send_file();
    wait_for_verdicts();

    run_random_phase(0, 0);
    run_random_phase(60, 0);
    run_random_phase(0, 60);
    run_random_phase(38, 38);

    // Hold off verdicts so the parser backs up onto its input
    idle_pct = 0;
    stall_pct = 0;
    hold_len = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 0) add_le(scp_pkg::TagGsnd, 4);
      add_noise($urandom_range(1, 2));
      send_file();
    end
    wait_for_verdicts();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/scp_pkg.sv
src/scp_stream_if.sv
src/sound_container_header_parser.sv
src/scp_checker.sv
tb/testbench.sv
